// ----- src/i2p_pkg.sv -----
// i2p_pkg: shared types and constants of the infix-to-postfix converter.
// Token and result words, classified items and stack entries.
// No dependencies.
package i2p_pkg;

	localparam int IN_QUEUE_DEPTH  = 2;
	localparam int OUT_QUEUE_DEPTH = 4;

	localparam logic [3:0] PREC_PAREN = 4'd9;

	typedef enum logic [2:0] {
		K_OPERAND  = 3'd0,
		K_OPERATOR = 3'd1,
		K_OPEN     = 3'd2,
		K_CLOSE    = 3'd3,
		K_END      = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_UNMATCHED = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [11:0] token_id;
		logic [7:0]  token_char;
	} token_t;

	typedef struct packed {
		logic [11:0] out_token_id;
		logic [7:0]  out_token_char;
		logic        token_valid;
		logic [1:0]  status;
		logic        last_of_run;
		logic        expression_done;
	} result_t;

	typedef struct packed {
		kind_t       kind;
		logic [11:0] id;
		logic [7:0]  ch;
		logic [3:0]  prec;
	} cls_t;

	typedef struct packed {
		logic [3:0]  prec;
		logic [7:0]  ch;
		logic [11:0] id;
	} entry_t;

endpackage

// ----- src/i2p_fifo.sv -----
// i2p_fifo: small synchronous first-in first-out queue of any packed type.
// Used for the front-to-back queue and the result queue.
// No dependencies.
module i2p_fifo #(
	parameter type item_t = logic [7:0],
	parameter int  DEPTH  = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  item_t wr_data,
	output logic  full,
	input  logic  rd_en,
	output item_t rd_data,
	output logic  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic  [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic  [CW-1:0] cnt_q;
	logic           do_wr, do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- src/i2p_front.sv -----
// i2p_front: accepts tokens, classifies them and derives operator precedence.
// Classified items wait in a short queue for the stack engine.
// Depends on i2p_pkg and i2p_fifo.
module i2p_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  i2p_pkg::token_t token,
	input  logic           q_pop,
	output i2p_pkg::cls_t  q_item,
	output logic           q_empty
);
	import i2p_pkg::*;

	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	localparam logic [3:0] PREC_FUNC = 4'd0;
	localparam logic [3:0] PREC_POW  = 4'd1;
	localparam logic [3:0] PREC_MUL  = 4'd2;
	localparam logic [3:0] PREC_ADD  = 4'd3;

	function automatic logic [3:0] char_prec(input logic [7:0] c);
		case (c)
			CH_CARET:          char_prec = PREC_POW;
			CH_STAR, CH_SLASH: char_prec = PREC_MUL;
			CH_PLUS, CH_MINUS: char_prec = PREC_ADD;
			default:           char_prec = PREC_FUNC;
		endcase
	endfunction

	cls_t cls;
	logic cmd_ok;

	// unused command codes are taken and dropped here
	assign cmd_ok = token.cmd inside {K_OPERAND, K_OPERATOR, K_OPEN, K_CLOSE, K_END};

	always_comb begin
		cls.kind = kind_t'(token.cmd);
		cls.id   = token.token_id;
		cls.ch   = token.token_char;
		case (token.cmd)
			K_OPERATOR: cls.prec = char_prec(token.token_char);
			K_OPEN:     cls.prec = PREC_PAREN;
			default:    cls.prec = PREC_FUNC;
		endcase
	end

	i2p_fifo #(
		.item_t (cls_t),
		.DEPTH  (IN_QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && cmd_ok),
		.wr_data (cls),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_item),
		.empty   (q_empty)
	);

endmodule

// ----- src/i2p_back.sv -----
// i2p_back: shunting-yard stack engine; pops, pushes and emits result words.
// The last result of a token is held back one step so it can be tagged.
// Depends on i2p_pkg.
module i2p_back #(
	parameter int STACK_DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_empty,
	input  i2p_pkg::cls_t    in_item,
	output logic             in_pop,
	input  logic             out_full,
	output logic             out_push,
	output i2p_pkg::result_t out_item
);
	import i2p_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(STACK_DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_RD, S_EV, S_FIN} state_t;

	function automatic result_t mk_tok(input entry_t e, input logic done);
		result_t r;
		r                 = '0;
		r.out_token_id    = e.id;
		r.out_token_char  = e.ch;
		r.token_valid     = 1'b1;
		r.status          = ST_OK;
		r.expression_done = done;
		return r;
	endfunction

	function automatic result_t mk_stat(input status_t st, input logic done);
		result_t r;
		r                 = '0;
		r.status          = st;
		r.expression_done = done;
		return r;
	endfunction

	state_t         state_q, state_d;
	logic  [CW-1:0] cnt_q, cnt_d;
	cls_t           cur_q, cur_d;
	result_t        hold_q, hold_d;
	logic           hold_v_q, hold_v_d;

	entry_t         mem_q [STACK_DEPTH];
	entry_t         top_q;
	logic  [AW-1:0] rd_addr;
	logic           m_we;
	entry_t         m_wd;

	logic           emit_en, fin;
	result_t        emit_r;
	logic           room;

	assign rd_addr = AW'(cnt_q - CW'(1));
	assign room    = (cnt_q < CNT_MAX);

	always_ff @(posedge clk) begin
		if (m_we) begin
			mem_q[cnt_q[AW-1:0]] <= m_wd;
		end
		top_q <= mem_q[rd_addr];
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cur_d    = cur_q;
		hold_d   = hold_q;
		hold_v_d = hold_v_q;
		in_pop   = 1'b0;
		out_push = 1'b0;
		out_item = hold_q;
		m_we     = 1'b0;
		m_wd     = '{prec: cur_q.prec, ch: cur_q.ch, id: cur_q.id};
		emit_en  = 1'b0;
		emit_r   = '0;
		fin      = 1'b0;

		if (!out_full) begin
			case (state_q)
				S_IDLE: begin
					if (!in_empty) begin
						in_pop = 1'b1;
						cur_d  = in_item;
						case (in_item.kind)
							K_OPERAND: begin
								out_push = 1'b1;
								out_item = mk_tok('{prec: in_item.prec, ch: in_item.ch,
									id: in_item.id}, 1'b0);
								out_item.last_of_run = 1'b1;
							end
							K_OPEN: begin
								if (room) begin
									m_we  = 1'b1;
									m_wd  = '{prec: in_item.prec, ch: in_item.ch,
										id: in_item.id};
									cnt_d = cnt_q + CW'(1);
								end else begin
									out_push = 1'b1;
									out_item = mk_stat(ST_FULL, 1'b0);
									out_item.last_of_run = 1'b1;
								end
							end
							K_OPERATOR, K_CLOSE, K_END: state_d = S_RD;
							default: ;
						endcase
					end
				end
				S_RD: begin
					if (cnt_q != '0) begin
						state_d = S_EV;
					end else begin
						state_d = S_FIN;
						case (cur_q.kind)
							K_OPERATOR: begin
								m_we  = 1'b1;
								cnt_d = cnt_q + CW'(1);
							end
							K_CLOSE: begin
								emit_en = 1'b1;
								emit_r  = mk_stat(ST_UNMATCHED, 1'b0);
							end
							K_END: begin
								// nothing stacked: still mark the end of expression
								if (!hold_v_q) begin
									emit_en = 1'b1;
									emit_r  = mk_stat(ST_OK, 1'b1);
								end
							end
							default: ;
						endcase
					end
				end
				S_EV: begin
					case (cur_q.kind)
						K_OPERATOR: begin
							if (cur_q.prec >= top_q.prec) begin
								emit_en = 1'b1;
								emit_r  = mk_tok(top_q, 1'b0);
								cnt_d   = cnt_q - CW'(1);
								state_d = S_RD;
							end else begin
								state_d = S_FIN;
								if (room) begin
									m_we  = 1'b1;
									cnt_d = cnt_q + CW'(1);
								end else begin
									emit_en = 1'b1;
									emit_r  = mk_stat(ST_FULL, 1'b0);
								end
							end
						end
						K_CLOSE: begin
							cnt_d = cnt_q - CW'(1);
							if (top_q.prec == PREC_PAREN) begin
								state_d = S_FIN;
							end else begin
								emit_en = 1'b1;
								emit_r  = mk_tok(top_q, 1'b0);
								state_d = S_RD;
							end
						end
						default: begin
							cnt_d   = cnt_q - CW'(1);
							emit_en = 1'b1;
							emit_r  = mk_tok(top_q, 1'b1);
							state_d = S_RD;
						end
					endcase
				end
				S_FIN: begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
				default: state_d = S_IDLE;
			endcase
		end

		// one-behind release of results
		if (emit_en) begin
			if (hold_v_q) begin
				out_push = 1'b1;
				out_item = hold_q;
			end
			hold_d   = emit_r;
			hold_v_d = 1'b1;
		end
		if (fin && hold_v_q) begin
			out_push             = 1'b1;
			out_item             = hold_q;
			out_item.last_of_run = 1'b1;
			hold_v_d             = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			hold_v_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			hold_v_q <= hold_v_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		hold_q <= hold_d;
	end

endmodule

// ----- src/infix_to_postfix_converter.sv -----
// infix_to_postfix_converter: top level of the token-level shunting-yard converter.
// Joins the front classifier, the stack engine and the result queue.
// Depends on i2p_pkg, i2p_fifo, i2p_front and i2p_back.
//
// Usage notes
// - Input side is a queue: a token word is taken on a clock edge with push high
//   and full low. Unused command codes are taken and dropped.
// - Output side is a queue: the oldest result word sits on result while empty is
//   low and leaves on an edge with pop high.
// - Operands: the engine writes the result word straight into the result queue.
// - Operators, close parens and end tokens: the engine takes the word, then for
//   each stack entry examined reads the top entry from the stack memory and then
//   decides; it reads once more when the stack runs empty, and then releases the
//   tagged last result. Open parens are handled as the word is taken.
// - The final result of each token is held one step inside the engine so that
//   last_of_run can be set on it.
// - A full result queue stalls the engine; the input queue keeps taking tokens
//   until it fills.
// - Reset clears the stack count and both queues; the stack memory itself is not
//   cleared and needs no clearing pass.
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  i2p_pkg::token_t  token,
	input  logic             pop,
	output logic             empty,
	output i2p_pkg::result_t result
);
	import i2p_pkg::*;

	cls_t    q_item;
	logic    q_empty, q_pop;
	result_t r_item;
	logic    r_push, r_full;

	// front: classify and queue
	i2p_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.token   (token),
		.q_pop   (q_pop),
		.q_item  (q_item),
		.q_empty (q_empty)
	);

	// back: operator stack engine
	i2p_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_empty (q_empty),
		.in_item  (q_item),
		.in_pop   (q_pop),
		.out_full (r_full),
		.out_push (r_push),
		.out_item (r_item)
	);

	// result queue decouples the engine from the receiver
	i2p_fifo #(
		.item_t (result_t),
		.DEPTH  (OUT_QUEUE_DEPTH)
	) u_result_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (r_push),
		.wr_data (r_item),
		.full    (r_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		r_push |-> !r_full)
		else $error("engine wrote a result word into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("engine took a token from an empty queue");

	a_status_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.token_valid) |->
			(result.out_token_id == '0 && result.out_token_char == '0))
		else $error("status-only word carries token data");

endmodule

// ----- dv/tb_top.sv -----
// tb_top: self-checking testbench of infix_to_postfix_converter.
// Directed and random token words are checked against a shunting-yard predictor.
// Depends on i2p_pkg and infix_to_postfix_converter.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import i2p_pkg::*;

	localparam int STACK_DEPTH   = 32;
	localparam int RANDOM_ITEMS  = 250;
	localparam int IDLE_PERCENT  = 37;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 200;
	// spare command codes, taken by the block and dropped
	localparam logic [2:0] FIRST_SPARE_CMD = 3'd5;
	localparam logic [2:0] LAST_SPARE_CMD  = 3'd7;
	// characters that carry a binding rank; anything else is a function
	localparam logic [7:0] CH_POW   = "^";
	localparam logic [7:0] CH_MUL   = "*";
	localparam logic [7:0] CH_DIV   = "/";
	localparam logic [7:0] CH_ADD   = "+";
	localparam logic [7:0] CH_SUB   = "-";
	localparam logic [7:0] CH_OPEN  = "(";
	localparam logic [7:0] CH_CLOSE = ")";
	localparam logic [3:0] RANK_FN  = 4'd0;
	localparam logic [3:0] RANK_POW = 4'd1;
	localparam logic [3:0] RANK_MUL = 4'd2;
	localparam logic [3:0] RANK_ADD = 4'd3;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    push   = 1'b0;
	logic    full;
	token_t  token  = '0;
	logic    pop    = 1'b0;
	logic    empty;
	result_t result;

	// stimulus waiting to be pushed, and postfix words still owed by the block
	token_t  pending_tokens[$];
	result_t postfix_due[$];

	// predictor's own copy of the operator stack
	entry_t      op_stack[STACK_DEPTH];
	int unsigned stack_fill = 0;

	int unsigned cycle_count  = 0;
	int unsigned error_count  = 0;
	int unsigned counted_items = 0;

	infix_to_postfix_converter #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.token(token),
		.pop(pop),
		.empty(empty),
		.result(result)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// lower rank binds tighter
	function automatic logic [3:0] bind_rank(logic [7:0] ch);
		case (ch)
			CH_POW:         return RANK_POW;
			CH_MUL, CH_DIV: return RANK_MUL;
			CH_ADD, CH_SUB: return RANK_ADD;
			default:        return RANK_FN;
		endcase
	endfunction

	function automatic result_t word_of(logic [11:0] id, logic [7:0] ch, logic valid,
			status_t st, logic done);
		result_t w;
		w.out_token_id    = id;
		w.out_token_char  = ch;
		w.token_valid     = valid;
		w.status          = st;
		w.last_of_run     = 1'b0;
		w.expression_done = done;
		return w;
	endfunction

	function automatic result_t entry_word(entry_t e, logic done);
		return word_of(e.id, e.ch, 1'b1, ST_OK, done);
	endfunction

	// returns 0 when the stack has no room, the token is then dropped
	function automatic bit stack_push(logic [11:0] id, logic [7:0] ch, logic [3:0] rank);
		if (stack_fill >= STACK_DEPTH)
			return 1'b0;
		op_stack[stack_fill] = '{prec: rank, ch: ch, id: id};
		stack_fill++;
		return 1'b1;
	endfunction

	// Works out every word one accepted token causes and queues them in order.
	task automatic predict_postfix(input token_t t);
		result_t     words[$];
		logic [3:0]  rank;
		bit          found;
		entry_t      e;
		found = 1'b0;
		case (t.cmd)
			K_OPERAND:
				words.push_back(word_of(t.token_id, t.token_char, 1'b1, ST_OK, 1'b0));
			K_OPERATOR: begin
				rank = bind_rank(t.token_char);
				// equal rank pops too, so a function after a function pops it
				while (stack_fill > 0 && rank >= op_stack[stack_fill - 1].prec) begin
					stack_fill--;
					words.push_back(entry_word(op_stack[stack_fill], 1'b0));
				end
				if (!stack_push(t.token_id, t.token_char, rank))
					words.push_back(word_of('0, '0, 1'b0, ST_FULL, 1'b0));
			end
			K_OPEN: begin
				if (!stack_push(t.token_id, t.token_char, PREC_PAREN))
					words.push_back(word_of('0, '0, 1'b0, ST_FULL, 1'b0));
			end
			K_CLOSE: begin
				while (stack_fill > 0 && !found) begin
					stack_fill--;
					e = op_stack[stack_fill];
					if (e.prec == PREC_PAREN)
						found = 1'b1;
					else
						words.push_back(entry_word(e, 1'b0));
				end
				// no open paren: stack is now empty, flag it
				if (!found)
					words.push_back(word_of('0, '0, 1'b0, ST_UNMATCHED, 1'b0));
			end
			K_END: begin
				// open parens left over are flushed like any entry
				while (stack_fill > 0) begin
					stack_fill--;
					words.push_back(entry_word(op_stack[stack_fill], 1'b1));
				end
				// empty stack still marks the end of the expression
				if (words.size() == 0)
					words.push_back(word_of('0, '0, 1'b0, ST_OK, 1'b1));
			end
			default: ;
		endcase
		if (words.size() > 0)
			words[$].last_of_run = 1'b1;
		foreach (words[i])
			postfix_due.push_back(words[i]);
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic add_token(logic [2:0] cmd, logic [11:0] id, logic [7:0] ch);
		token_t t;
		t.cmd        = cmd;
		t.token_id   = id;
		t.token_char = ch;
		pending_tokens.push_back(t);
		if (cmd <= K_END)
			counted_items++;
	endtask

	function automatic logic [11:0] any_id();
		return 12'($urandom_range(0, 4095));
	endfunction

	function automatic logic [7:0] any_char();
		return 8'($urandom_range(0, 255));
	endfunction

	// operator character, a function now and then
	function automatic logic [7:0] op_char();
		case ($urandom_range(0, 5))
			0:       return CH_POW;
			1:       return CH_MUL;
			2:       return CH_DIV;
			3:       return CH_ADD;
			4:       return CH_SUB;
			default: return any_char();
		endcase
	endfunction

	// A mostly well-formed expression: terms joined by operators, some bracketed,
	// some behind a function, ending with an end token.
	task automatic add_expression();
		int terms;
		int opens;
		terms = $urandom_range(1, 6);
		opens = 0;
		for (int i = 0; i < terms; i++) begin
			if ($urandom_range(0, 9) < 2) begin
				add_token(K_OPERATOR, any_id(), any_char());
				add_token(K_OPEN, any_id(), CH_OPEN);
				opens++;
			end else if ($urandom_range(0, 9) < 3) begin
				add_token(K_OPEN, any_id(), CH_OPEN);
				opens++;
			end
			add_token(K_OPERAND, any_id(), any_char());
			if (opens > 0 && $urandom_range(0, 9) < 4) begin
				add_token(K_CLOSE, any_id(), CH_CLOSE);
				opens--;
			end
			if (i != terms - 1)
				add_token(K_OPERATOR, any_id(), op_char());
		end
		// leave some parens open for the end token to flush
		while (opens > 0 && $urandom_range(0, 9) < 8) begin
			add_token(K_CLOSE, any_id(), CH_CLOSE);
			opens--;
		end
		// a stray close paren now and then
		if ($urandom_range(0, 19) == 0)
			add_token(K_CLOSE, any_id(), CH_CLOSE);
		add_token(K_END, any_id(), any_char());
	endtask

	// Nesting to the stack depth or past it: overflow on operator, and on open paren when past it.
	task automatic add_deep_nest();
		int depth;
		depth = STACK_DEPTH + $urandom_range(0, 2);
		repeat (depth)
			add_token(K_OPEN, any_id(), CH_OPEN);
		add_token(K_OPERATOR, any_id(), op_char());
		add_token(K_OPERAND, any_id(), any_char());
		add_token(K_END, any_id(), any_char());
	endtask

	// ------------------------------------------------------------------
	// Idling: about IDLE_PERCENT of cycles idle, apart from a recurring quiet window
	// at the start of each period of cycle_count where both sides run flat out.
	// ------------------------------------------------------------------
	function automatic bit take_break();
		if ((cycle_count % 6000) < 1500)
			return 1'b0;
		return $urandom_range(0, 99) < IDLE_PERCENT;
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] postfix mismatch: %s", $time, what);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// Driver: offers the next pending word on the falling edge; the word is
	// taken on the rising edge with push high and full low, and only then is
	// it handed to the predictor.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && pending_tokens.size() > 0 && !take_break()) begin
			push  <= 1'b1;
			token <= pending_tokens[0];
		end else begin
			push  <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			predict_postfix(token);
			void'(pending_tokens.pop_front());
		end
	end

	// ------------------------------------------------------------------
	// Monitor: pop raised at random on the falling edge, the head word
	// checked against the oldest expectation on the rising edge.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		pop <= arst_n && !take_break();
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (postfix_due.size() == 0) begin
				report_mismatch($sformatf("unexpected word id %h char %h status %0d",
					result.out_token_id, result.out_token_char, result.status));
			end else begin
				want = postfix_due.pop_front();
				if (result.out_token_id !== want.out_token_id)
					report_mismatch($sformatf("out_token_id got %h want %h",
						result.out_token_id, want.out_token_id));
				if (result.out_token_char !== want.out_token_char)
					report_mismatch($sformatf("out_token_char got %h want %h",
						result.out_token_char, want.out_token_char));
				if (result.token_valid !== want.token_valid)
					report_mismatch($sformatf("token_valid got %b want %b",
						result.token_valid, want.token_valid));
				if (result.status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d",
						result.status, want.status));
				if (result.last_of_run !== want.last_of_run)
					report_mismatch($sformatf("last_of_run got %b want %b",
						result.last_of_run, want.last_of_run));
				if (result.expression_done !== want.expression_done)
					report_mismatch($sformatf("expression_done got %b want %b",
						result.expression_done, want.expression_done));
			end
		end
	end

	// watchdog on a hung block
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence: build all stimulus, reset, then drain and give the verdict.
	// ------------------------------------------------------------------
	initial begin
		// directed: empty end, field extremes, every operator, special cases
		add_token(K_END, 12'hFFF, 8'hFF);                // end on empty stack
		add_token(K_OPERAND, 12'hFFF, 8'hFF);
		add_token(K_OPERAND, 12'h000, 8'h00);
		add_token(K_OPEN, 12'h001, CH_OPEN);
		add_token(K_OPERATOR, 12'h002, CH_ADD);
		add_token(K_OPERAND, 12'h003, "a");
		add_token(K_OPERATOR, 12'h004, CH_MUL);
		add_token(K_OPERAND, 12'h005, "b");
		add_token(K_OPERATOR, 12'h006, CH_POW);
		add_token(K_OPERATOR, 12'h007, CH_DIV);          // pops ^ and *
		add_token(K_OPERATOR, 12'h008, CH_SUB);          // pops / and +
		add_token(K_CLOSE, 12'h009, CH_CLOSE);           // emits down to the paren
		add_token(K_OPERATOR, 12'h00A, "f");             // function
		add_token(K_OPERATOR, 12'h00B, "s");             // function pops function
		add_token(K_OPEN, 12'h00C, CH_OPEN);
		add_token(K_CLOSE, 12'h00D, CH_CLOSE);           // paren found at once
		add_token(K_CLOSE, 12'h00E, CH_CLOSE);           // unmatched
		add_token(K_OPEN, 12'h00F, CH_OPEN);
		add_token(K_OPEN, 12'h010, CH_OPEN);
		for (int c = FIRST_SPARE_CMD; c <= LAST_SPARE_CMD; c++)
			add_token(3'(c), 12'hFFF, 8'hFF);             // spare codes are dropped
		add_token(K_END, 12'h011, 8'h00);                // flushes open parens

		// random: mostly expressions, some noise, now and then an overflow
		add_deep_nest();
		while (counted_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 99)) inside
				[0:79]:  add_expression();
				[80:96]: repeat ($urandom_range(1, 4))
					add_token(3'($urandom_range(0, 7)), any_id(), any_char());
				default: add_deep_nest();
			endcase
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_tokens.size() > 0 || postfix_due.size() > 0)
			@(posedge clk);
		// tokens that owe no word may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/i2p_pkg.sv
src/i2p_fifo.sv
src/i2p_front.sv
src/i2p_back.sv
src/infix_to_postfix_converter.sv
dv/tb_top.sv
